/* sv/i2cm_pkg.sv */
package i2cm_pkg;

   // input actions
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_STOP  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ACK_TO  = 2'd1;
   localparam logic [1:0] ST_BUSBUSY = 2'd2;
   localparam logic [1:0] ST_REJECT  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_WRITE_HALF = 2'd0;
   localparam logic [1:0] CSR_READ_HALF  = 2'd1;
   localparam logic [1:0] CSR_ACK_TO     = 2'd2;

   localparam int BITS_PER_BYTE = 8;

   typedef struct packed {
      logic [7:0] write_half_ticks;
      logic [7:0] read_half_ticks;
      logic [7:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic [1:0] status;
   } rsp_type;

   // delay reload value for a half period; zero acts as one
   function automatic logic [7:0] half_of(input logic [7:0] v);
      half_of = (v == 8'd0) ? 8'd0 : v - 8'd1;
   endfunction

endpackage

/* sv/i2cm_if.sv */
interface i2cm_req_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface i2cm_rsp_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/i2cm_core.sv */
module i2cm_core
   import i2cm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_ST1  = 4'd1;
   localparam logic [3:0] PH_ST2  = 4'd2;
   localparam logic [3:0] PH_SP1  = 4'd3;
   localparam logic [3:0] PH_SP2  = 4'd4;
   localparam logic [3:0] PH_SP3  = 4'd5;
   localparam logic [3:0] PH_WL   = 4'd6;
   localparam logic [3:0] PH_WH   = 4'd7;
   localparam logic [3:0] PH_AL   = 4'd8;
   localparam logic [3:0] PH_AH   = 4'd9;
   localparam logic [3:0] PH_RL   = 4'd10;
   localparam logic [3:0] PH_RH   = 4'd11;
   localparam logic [3:0] PH_KL   = 4'd12;
   localparam logic [3:0] PH_KH   = 4'd13;

   logic [3:0] phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] delay_ff, delay_in;
   logic [7:0] poll_ff, poll_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in_nxt;
   logic       ack_choice_ff, ack_choice_in;
   logic [7:0] rx_hold_ff, rx_hold_in;
   logic [1:0] pend_ff, pend_in;
   logic       done;
   logic [1:0] st;
   logic [3:0] bc_inc;
   logic [7:0] shift_up;
   logic [7:0] wr_half;
   logic [7:0] rd_half;

   assign bc_inc   = bit_count_ff + 4'd1;
   assign shift_up = {shift_ff[6:0], 1'b0};
   assign wr_half  = half_of(cfg.write_half_ticks);
   assign rd_half  = half_of(cfg.read_half_ticks);

   // next state for one tick
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      delay_in      = delay_ff;
      poll_in       = poll_ff;
      scl_in        = scl_ff;
      sda_in_nxt    = sda_ff;
      ack_choice_in = ack_choice_ff;
      rx_hold_in    = rx_hold_ff;
      pend_in       = pend_ff;
      done          = 1'b0;
      st            = ST_OK;
      if (step_en) begin
         if (phase_ff == PH_IDLE) begin
            case (item.action)
               ACT_TICK: ;
               ACT_START: begin
                  scl_in = 1'b1; sda_in_nxt = 1'b0;
                  phase_in = PH_ST1; delay_in = wr_half;
               end
               ACT_STOP: begin
                  pend_in = ST_OK; scl_in = 1'b0; sda_in_nxt = 1'b1;
                  phase_in = PH_SP1; delay_in = wr_half;
               end
               ACT_WRITE: begin
                  shift_in = item.tx_byte; bit_count_in = 4'd0; scl_in = 1'b0;
                  sda_in_nxt = ~item.tx_byte[7];
                  phase_in = PH_WL; delay_in = wr_half;
               end
               ACT_READ: begin
                  ack_choice_in = item.send_ack; bit_count_in = 4'd0; shift_in = 8'd0;
                  scl_in = 1'b0; sda_in_nxt = 1'b0;
                  phase_in = PH_RL; delay_in = rd_half;
               end
               default: st = ST_REJECT;
            endcase
         end else begin
            if (item.action != ACT_TICK) st = ST_REJECT;
            if (delay_ff != 8'd0) begin
               delay_in = delay_ff - 8'd1;
            end else begin
               unique case (phase_ff)
                  PH_ST1: begin
                     if (!item.sda_in) begin
                        scl_in = 1'b1; sda_in_nxt = 1'b0; phase_in = PH_IDLE;
                        done = 1'b1; st = ST_BUSBUSY;
                     end else begin
                        sda_in_nxt = 1'b1; phase_in = PH_ST2; delay_in = wr_half;
                     end
                  end
                  PH_ST2: begin
                     phase_in = PH_IDLE; done = 1'b1;
                     if (item.sda_in) begin
                        sda_in_nxt = 1'b0; st = ST_BUSBUSY;
                     end else begin
                        scl_in = 1'b0; st = ST_OK;
                     end
                  end
                  PH_SP1: begin
                     scl_in = 1'b1; phase_in = PH_SP2; delay_in = wr_half;
                  end
                  PH_SP2: begin
                     sda_in_nxt = 1'b0; phase_in = PH_SP3; delay_in = wr_half;
                  end
                  PH_SP3: begin
                     phase_in = PH_IDLE; done = 1'b1; st = pend_ff; pend_in = ST_OK;
                  end
                  PH_WL: begin
                     scl_in = 1'b1; phase_in = PH_WH; delay_in = wr_half;
                  end
                  PH_WH: begin
                     scl_in = 1'b0; shift_in = shift_up; bit_count_in = bc_inc;
                     delay_in = wr_half;
                     if (bc_inc >= 4'(BITS_PER_BYTE)) begin
                        sda_in_nxt = 1'b0; phase_in = PH_AL;
                     end else begin
                        sda_in_nxt = ~shift_up[7]; phase_in = PH_WL;
                     end
                  end
                  PH_AL: begin
                     scl_in = 1'b1; poll_in = 8'd0; phase_in = PH_AH; delay_in = wr_half;
                  end
                  PH_AH: begin
                     if (!item.sda_in) begin
                        scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1; st = ST_OK;
                     end else if (poll_ff >= cfg.ack_timeout) begin
                        // give up: issue a stop, report timeout at its end
                        pend_in = ST_ACK_TO; scl_in = 1'b0; sda_in_nxt = 1'b1;
                        phase_in = PH_SP1; delay_in = wr_half;
                     end else begin
                        poll_in = poll_ff + 8'd1;
                     end
                  end
                  PH_RL: begin
                     scl_in = 1'b1; phase_in = PH_RH; delay_in = rd_half;
                  end
                  PH_RH: begin
                     shift_in = {shift_ff[6:0], item.sda_in}; bit_count_in = bc_inc;
                     scl_in = 1'b0;
                     if (bc_inc >= 4'(BITS_PER_BYTE)) begin
                        sda_in_nxt = ack_choice_ff; phase_in = PH_KL; delay_in = wr_half;
                     end else begin
                        phase_in = PH_RL; delay_in = rd_half;
                     end
                  end
                  PH_KL: begin
                     scl_in = 1'b1; phase_in = PH_KH; delay_in = wr_half;
                  end
                  PH_KH: begin
                     scl_in = 1'b0; sda_in_nxt = 1'b0; rx_hold_in = shift_ff;
                     phase_in = PH_IDLE; done = 1'b1; st = ST_OK;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         delay_ff      <= 8'd0;
         poll_ff       <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b0;
         ack_choice_ff <= 1'b0;
         rx_hold_ff    <= 8'd0;
         pend_ff       <= ST_OK;
      end else begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         delay_ff      <= delay_in;
         poll_ff       <= poll_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in_nxt;
         ack_choice_ff <= ack_choice_in;
         rx_hold_ff    <= rx_hold_in;
         pend_ff       <= pend_in;
      end
   end

   // result of this tick, seen after the update
   always_comb begin
      result.scl_level    = scl_in;
      result.sda_pull_low = sda_in_nxt;
      result.busy_res     = (phase_in != PH_IDLE);
      result.done_res     = done;
      result.rx_byte      = rx_hold_in;
      result.status       = st;
   end

endmodule

/* sv/i2c_master_bit_engine.sv */
// channel   direction  beat content
// req_ch    in         action, tx_byte, send_ack, sda_in (one bus tick)
// rsp_ch    out        scl_level, sda_pull_low, busy_res, done_res, rx_byte, status
// csr_*     in         write enable, 2-bit register index, 8-bit data
//
// one request beat per clock while the output register is empty or being drained, each giving exactly one response beat
// the tick update is one pass of the phase sequencer into the state registers;
// the response sits in an output register from the cycle after acceptance
// reset (synchronous, active high) returns to idle, scl released, registers to defaults
// a request is taken whenever the output register is empty or being drained
module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_ch,
   i2cm_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type cfg_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   rsp_type core_rsp;
   logic    accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.write_half_ticks <= 8'd1;
         cfg_ff.read_half_ticks  <= 8'd2;
         cfg_ff.ack_timeout      <= 8'd50;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WRITE_HALF: cfg_ff.write_half_ticks <= csr_wdata;
            CSR_READ_HALF:  cfg_ff.read_half_ticks  <= csr_wdata;
            CSR_ACK_TO:     cfg_ff.ack_timeout      <= csr_wdata;
            default: ;
         endcase
      end
   end

   i2cm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .item    (req_ch.data),
      .cfg     (cfg_ff),
      .result  (core_rsp)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

endmodule

/* tb/sv/tb_i2c_master_bit_engine.sv */
module tb_i2c_master_bit_engine;
   import i2cm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // action codes with no command behind them
   localparam logic [2:0] ACT_RSVD5 = 3'd5;
   localparam logic [2:0] ACT_RSVD6 = 3'd6;
   localparam logic [2:0] ACT_RSVD7 = 3'd7;

   // bus sequencer phases of the predictor
   typedef enum logic [4:0] {
      BUS_IDLE, START_HOLD, START_EDGE, STOP_LOW, STOP_RISE, STOP_SETTLE,
      WR_LOW, WR_HIGH, ACK_LOW, ACK_HIGH, RD_LOW, RD_HIGH, RACK_LOW, RACK_HIGH
   } seq_phase_type;

   // one row of the directed table, repeated reps times
   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx;
      logic       ack;
      logic       sda;
      logic [7:0] reps;
      logic       typed;
      rsp_type    fixed;
   } stim_row_type;

   localparam rsp_type IDLE_OK = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b0,
                                   done_res: 1'b0, rx_byte: 8'h00, status: ST_OK};
   localparam rsp_type IDLE_REJECT = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b0,
                                       done_res: 1'b0, rx_byte: 8'h00, status: ST_REJECT};

   localparam stim_row_type DIRECTED_ROWS [28] = '{
      // after reset, then unknown actions while idle
      '{ACT_TICK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b1, IDLE_OK},
      '{ACT_RSVD5, 8'hFF, 1'b1, 1'b1, 8'd1,  1'b1, IDLE_REJECT},
      '{ACT_RSVD6, 8'h00, 1'b0, 1'b0, 8'd1,  1'b1, IDLE_REJECT},
      '{ACT_RSVD7, 8'h5A, 1'b1, 1'b0, 8'd1,  1'b1, IDLE_REJECT},
      // stop from idle
      '{ACT_STOP,  8'h00, 1'b0, 1'b1, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b1, 8'd3,  1'b0, IDLE_OK},
      // start with sda held low by another master
      '{ACT_START, 8'h00, 1'b0, 1'b0, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, IDLE_OK},
      // start whose falling sda edge never shows up
      '{ACT_START, 8'h00, 1'b0, 1'b1, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b1, 8'd2,  1'b0, IDLE_OK},
      // clean start
      '{ACT_START, 8'h00, 1'b0, 1'b1, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b1, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, IDLE_OK},
      // write all ones, a command arriving mid-byte, ack after a few polls
      '{ACT_WRITE, 8'hFF, 1'b0, 1'b1, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'hFF, 1'b1, 1'b1, 8'd8,  1'b0, IDLE_OK},
      '{ACT_READ,  8'h00, 1'b1, 1'b1, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b1, 8'd8,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b1, 8'd3,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, IDLE_OK},
      // write all zeros, never acked: timeout and stop
      '{ACT_WRITE, 8'h00, 1'b0, 1'b1, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b1, 8'd72, 1'b0, IDLE_OK},
      // read with ack, then read with nack
      '{ACT_READ,  8'h00, 1'b1, 1'b1, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b1, 8'd17, 1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b0, 8'd17, 1'b0, IDLE_OK},
      '{ACT_READ,  8'hFF, 1'b0, 1'b0, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b1, 8'd34, 1'b0, IDLE_OK},
      '{ACT_STOP,  8'h00, 1'b0, 1'b0, 8'd1,  1'b0, IDLE_OK},
      '{ACT_TICK,  8'h00, 1'b0, 1'b0, 8'd3,  1'b0, IDLE_OK}
   };

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   i2cm_req_if req_ch ();
   i2cm_rsp_if rsp_ch ();

   i2c_master_bit_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and its copy of the registers
   cfg_type       active_cfg = '{write_half_ticks: 8'd1, read_half_ticks: 8'd2,
                                 ack_timeout: 8'd50};
   seq_phase_type eng_phase = BUS_IDLE;
   logic [3:0]    eng_bits = 4'd0;
   logic [7:0]    eng_shift = 8'h00;
   logic [7:0]    eng_wait = 8'h00;
   logic [7:0]    eng_polls = 8'h00;
   logic          eng_scl = 1'b1;
   logic          eng_sda_low = 1'b0;
   logic          eng_ack = 1'b0;
   logic [7:0]    eng_rx = 8'h00;
   logic [1:0]    eng_stop_code = ST_OK;

   rsp_type    expected_q [$];
   int         item_count = 0;
   int         mismatches = 0;
   bit         calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   // load a phase counter with one half period, zero counts as one
   task automatic enter(input seq_phase_type p, input logic [7:0] half);
      eng_phase = p;
      eng_wait = (half != 8'd0) ? half - 8'd1 : 8'd0;
   endtask

   task automatic launch_stop(input logic [1:0] code);
      eng_stop_code = code;
      eng_scl = 1'b0;
      eng_sda_low = 1'b1;
      enter(STOP_LOW, active_cfg.write_half_ticks);
   endtask

   // one bus tick of the sequencer, returns the expected response beat
   task automatic advance_bus(input req_type it, output rsp_type r);
      logic       fin;
      logic [1:0] code;
      logic [7:0] wh;
      logic [7:0] rh;
      fin = 1'b0;
      code = ST_OK;
      wh = active_cfg.write_half_ticks;
      rh = active_cfg.read_half_ticks;
      if (eng_phase == BUS_IDLE) begin
         case (it.action)
            ACT_TICK: ;
            ACT_START: begin
               eng_scl = 1'b1;
               eng_sda_low = 1'b0;
               enter(START_HOLD, wh);
            end
            ACT_STOP: launch_stop(ST_OK);
            ACT_WRITE: begin
               eng_shift = it.tx_byte;
               eng_bits = 4'd0;
               eng_scl = 1'b0;
               eng_sda_low = ~it.tx_byte[7];
               enter(WR_LOW, wh);
            end
            ACT_READ: begin
               eng_ack = it.send_ack;
               eng_bits = 4'd0;
               eng_shift = 8'h00;
               eng_scl = 1'b0;
               eng_sda_low = 1'b0;
               enter(RD_LOW, rh);
            end
            default: code = ST_REJECT;
         endcase
      end else begin
         // commands are refused while a sequence runs
         if (it.action != ACT_TICK) code = ST_REJECT;
         if (eng_wait != 8'd0) begin
            eng_wait = eng_wait - 8'd1;
         end else begin
            case (eng_phase)
               START_HOLD: begin
                  if (!it.sda_in) begin
                     eng_scl = 1'b1;
                     eng_sda_low = 1'b0;
                     eng_phase = BUS_IDLE;
                     fin = 1'b1;
                     code = ST_BUSBUSY;
                  end else begin
                     eng_sda_low = 1'b1;
                     enter(START_EDGE, wh);
                  end
               end
               START_EDGE: begin
                  eng_phase = BUS_IDLE;
                  fin = 1'b1;
                  if (it.sda_in) begin
                     eng_sda_low = 1'b0;
                     code = ST_BUSBUSY;
                  end else begin
                     eng_scl = 1'b0;
                     code = ST_OK;
                  end
               end
               STOP_LOW: begin
                  eng_scl = 1'b1;
                  enter(STOP_RISE, wh);
               end
               STOP_RISE: begin
                  eng_sda_low = 1'b0;
                  enter(STOP_SETTLE, wh);
               end
               STOP_SETTLE: begin
                  eng_phase = BUS_IDLE;
                  fin = 1'b1;
                  code = eng_stop_code;
                  eng_stop_code = ST_OK;
               end
               WR_LOW: begin
                  eng_scl = 1'b1;
                  enter(WR_HIGH, wh);
               end
               WR_HIGH: begin
                  eng_scl = 1'b0;
                  eng_shift = eng_shift << 1;
                  eng_bits = eng_bits + 4'd1;
                  if (eng_bits >= 4'd8) begin
                     eng_sda_low = 1'b0;
                     enter(ACK_LOW, wh);
                  end else begin
                     eng_sda_low = ~eng_shift[7];
                     enter(WR_LOW, wh);
                  end
               end
               ACK_LOW: begin
                  eng_scl = 1'b1;
                  eng_polls = 8'd0;
                  enter(ACK_HIGH, wh);
               end
               ACK_HIGH: begin
                  if (!it.sda_in) begin
                     eng_scl = 1'b0;
                     eng_phase = BUS_IDLE;
                     fin = 1'b1;
                     code = ST_OK;
                  end else if (eng_polls >= active_cfg.ack_timeout) begin
                     launch_stop(ST_ACK_TO);
                  end else begin
                     eng_polls = eng_polls + 8'd1;
                  end
               end
               RD_LOW: begin
                  eng_scl = 1'b1;
                  enter(RD_HIGH, rh);
               end
               RD_HIGH: begin
                  eng_shift = {eng_shift[6:0], it.sda_in};
                  eng_bits = eng_bits + 4'd1;
                  eng_scl = 1'b0;
                  if (eng_bits >= 4'd8) begin
                     eng_sda_low = eng_ack;
                     enter(RACK_LOW, wh);
                  end else begin
                     enter(RD_LOW, rh);
                  end
               end
               RACK_LOW: begin
                  eng_scl = 1'b1;
                  enter(RACK_HIGH, wh);
               end
               RACK_HIGH: begin
                  eng_scl = 1'b0;
                  eng_sda_low = 1'b0;
                  eng_rx = eng_shift;
                  eng_phase = BUS_IDLE;
                  fin = 1'b1;
                  code = ST_OK;
               end
               default: eng_phase = BUS_IDLE;
            endcase
         end
      end
      r.scl_level = eng_scl;
      r.sda_pull_low = eng_sda_low;
      r.busy_res = (eng_phase != BUS_IDLE);
      r.done_res = fin;
      r.rx_byte = eng_rx;
      r.status = code;
   endtask

   // send one request beat; the expectation is recorded at the accepting edge
   task automatic push_item(input req_type it, input bit typed, input rsp_type fixed);
      rsp_type predicted;
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_bus(it, predicted);
      expected_q.push_back(typed ? fixed : predicted);
      item_count++;
      @(negedge clock);
   endtask

   // sda as a well-behaved slave would show it, or plain noise
   function automatic logic bus_sda(input bit coop, input int ack_after);
      if (!coop) return 1'($urandom_range(0, 1));
      case (eng_phase)
         START_HOLD: return 1'b1;
         START_EDGE: return 1'b0;
         ACK_HIGH:   return (int'(eng_polls) >= ack_after) ? 1'b0 : 1'b1;
         default:    return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // issue one command and tick until the sequencer is back to idle
   task automatic run_op(input logic [2:0] op, input bit coop);
      req_type it;
      int      ack_after;
      ack_after = ($urandom_range(0, 3) == 0) ? int'(active_cfg.ack_timeout) + 1
                                              : int'($urandom_range(0, 3));
      it.action = op;
      it.tx_byte = 8'($urandom);
      it.send_ack = 1'($urandom_range(0, 1));
      it.sda_in = bus_sda(coop, ack_after);
      push_item(it, 1'b0, '0);
      while (eng_phase != BUS_IDLE) begin
         it.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(1, 7)) : ACT_TICK;
         it.tx_byte = 8'($urandom);
         it.send_ack = 1'($urandom_range(0, 1));
         it.sda_in = bus_sda(coop, ack_after);
         push_item(it, 1'b0, '0);
      end
   endtask

   // mostly whole command sequences, some stray beats in between
   task automatic run_random(input int n);
      int      stop_at;
      req_type it;
      stop_at = item_count + n;
      while (item_count < stop_at) begin
         if ($urandom_range(0, 9) < 2) begin
            it.action = 3'($urandom_range(0, 7));
            it.tx_byte = 8'($urandom);
            it.send_ack = 1'($urandom_range(0, 1));
            it.sda_in = 1'($urandom_range(0, 1));
            push_item(it, 1'b0, '0);
         end else begin
            run_op(3'($urandom_range(1, 4)), $urandom_range(0, 9) != 0);
         end
      end
      if (eng_phase != BUS_IDLE) run_op(ACT_TICK, 1'b1);
   endtask

   // hold requests back until every response beat is in
   task automatic settle;
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_config(input logic [7:0] wh, input logic [7:0] rh,
                              input logic [7:0] ato);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_WRITE_HALF;
      csr_wdata <= wh;
      @(negedge clock);
      csr_index <= CSR_READ_HALF;
      csr_wdata <= rh;
      @(negedge clock);
      csr_index <= CSR_ACK_TO;
      csr_wdata <= ato;
      @(negedge clock);
      csr_we <= 1'b0;
      active_cfg.write_half_ticks = wh;
      active_cfg.read_half_ticks = rh;
      active_cfg.ack_timeout = ato;
   endtask

   // response side stalls at random, except while calm is set
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $error("response beat with nothing expected");
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            check_field("scl_level", want.scl_level, rsp_ch.data.scl_level);
            check_field("sda_pull_low", want.sda_pull_low, rsp_ch.data.sda_pull_low);
            check_field("busy_res", want.busy_res, rsp_ch.data.busy_res);
            check_field("done_res", want.done_res, rsp_ch.data.done_res);
            check_field("rx_byte", want.rx_byte, rsp_ch.data.rx_byte);
            check_field("status", want.status, rsp_ch.data.status);
         end
      end
   end

   initial begin
      req_type      it;
      stim_row_type row;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_we = 1'b0;
      csr_index = CSR_WRITE_HALF;
      csr_wdata = 8'h00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table at reset register values
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         row = DIRECTED_ROWS[i];
         it.action = row.action;
         it.tx_byte = row.tx;
         it.send_ack = row.ack;
         it.sda_in = row.sda;
         for (int k = 0; k < int'(row.reps); k++) push_item(it, row.typed, row.fixed);
      end
      run_random(120);

      // shortest half periods and timeout
      load_config(8'd1, 8'd1, 8'd1);
      run_random(80);

      // zero registers, with no stalls on either side
      calm = 1'b1;
      load_config(8'd0, 8'd0, 8'd0);
      run_random(60);
      calm = 1'b0;

      // longest ack timeout, one sequence of each kind
      load_config(8'd4, 8'd3, 8'd255);
      run_op(ACT_START, 1'b1);
      run_op(ACT_WRITE, 1'b1);
      run_op(ACT_READ, 1'b1);
      run_op(ACT_STOP, 1'b1);

      // a few random small settings
      repeat (3) begin
         load_config(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                     8'($urandom_range(1, 6)));
         run_random(50);
      end

      settle();
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
